/* rtl/hrhp_pkg.sv */
// shared types and constants for the http response header parser
package hrhp_pkg;

	localparam int unsigned MAX_PAIRS  = 128;
	localparam int unsigned MAX_BYTES  = 1114112;
	localparam int unsigned CNT_W      = $clog2(MAX_BYTES + 1);
	localparam int unsigned OUT_W      = 21;
	localparam int unsigned STAT_W     = 11;
	localparam int unsigned PAIR_W     = 8;
	localparam int unsigned DIG_W      = 10;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned TAG_LEN    = 5;

	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic KIND_PAIR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;
	localparam logic OP_DATA      = 1'b0;
	localparam logic OP_END       = 1'b1;

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_SCAN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic                     kind;
		logic [OUT_W-1:0]         name_off;
		logic [OUT_W-1:0]         name_size;
		logic [OUT_W-1:0]         val_off;
		logic [OUT_W-1:0]         val_len;
		logic signed [STAT_W-1:0] status;
		logic [PAIR_W-1:0]        pairs;
		logic [OUT_W-1:0]         body_off;
		logic                     last;
	} rec_t;

	// bytes of the "HTTP/" prefix
	function automatic logic [7:0] tag_byte(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h48;
			3'd1: ch = 8'h54;
			3'd2: ch = 8'h54;
			3'd3: ch = 8'h50;
			3'd4: ch = 8'h2f;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/http_response_header_parser_top.sv */
// http response header parser: byte stream in, header span and summary records out
//
// Takes one response byte (or the end marker) per cycle while s_tready is high; every
// byte is handled in the cycle it is accepted and its records go into a four-entry
// output queue that drains one record per cycle while m_tready is high. Data bytes give
// at most one record, the end marker up to two (a pending header pair and the summary),
// so s_tready drops only while the queue has fewer than two free entries.
module http_response_header_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // name_offset, name_length, value_offset, value_length,
	                                // status_code, pairs_found, body_offset, zero fill
	output logic         m_tuser,   // record_kind
	output logic         m_tlast    // last_record
);
	import hrhp_pkg::*;

	// parser state
	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   byte_off_q, byte_off_d;
	logic [2:0]         prefix_idx_q, prefix_idx_d;
	logic [DIG_W-1:0]   digits_q, digits_d;
	logic               status_ok_q, status_ok_d;
	logic [1:0]         digit_idx_q, digit_idx_d;
	logic               first_done_q, first_done_d;
	logic [CNT_W-1:0]   line_begin_q, line_begin_d;
	logic               colon_seen_q, colon_seen_d;
	logic [CNT_W-1:0]   colon_off_q, colon_off_d;
	logic [CNT_W-1:0]   val_begin_q, val_begin_d;
	logic               skipping_q, skipping_d;
	logic               prev_cr_q, prev_cr_d;
	logic [PAIR_W-1:0]  pair_total_q, pair_total_d;
	logic [CNT_W-1:0]   body_begin_q, body_begin_d;
	logic               body_found_q, body_found_d;

	// output queue
	rec_t               fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0]  cnt_q;

	logic               in_xfer, out_xfer;
	logic [7:0]         b;
	rec_t               rec_a, rec_b;
	logic [1:0]         push_n;

	// line close datapath, shared by the lf and end marker cases
	logic [CNT_W-1:0]   le, le_inc, text_end, vs;
	logic               line_empty, pair_ok;
	logic [13:0]        dig_acc;
	logic               is_digit;
	logic [OUT_W-1:0]   len_out;

	assign b        = s_tdata;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign s_tready = cnt_q <= FCNT_W'(FIFO_DEPTH - 2);
	assign m_tvalid = cnt_q != '0;

	assign le          = byte_off_q;
	assign le_inc      = le + CNT_W'(1);
	assign text_end    = (le > line_begin_q && prev_cr_q) ? le - CNT_W'(1) : le;
	assign line_empty  = text_end == line_begin_q;
	assign vs          = (val_begin_q < text_end) ? val_begin_q : text_end;
	assign pair_ok     = colon_seen_q && (pair_total_q < PAIR_W'(MAX_PAIRS)) && !line_empty;
	assign is_digit    = b >= CH_ZERO && b <= CH_NINE;
	assign dig_acc     = ({4'b0, digits_q} << 3) + ({4'b0, digits_q} << 1) + {10'b0, b[3:0]};
	assign len_out     = OUT_W'(le);

	always_comb begin
		phase_d      = phase_q;
		byte_off_d   = byte_off_q;
		prefix_idx_d = prefix_idx_q;
		digits_d     = digits_q;
		status_ok_d  = status_ok_q;
		digit_idx_d  = digit_idx_q;
		first_done_d = first_done_q;
		line_begin_d = line_begin_q;
		colon_seen_d = colon_seen_q;
		colon_off_d  = colon_off_q;
		val_begin_d  = val_begin_q;
		skipping_d   = skipping_q;
		prev_cr_d    = prev_cr_q;
		pair_total_d = pair_total_q;
		body_begin_d = body_begin_q;
		body_found_d = body_found_q;
		push_n       = 2'd0;

		rec_a           = '0;
		rec_a.kind      = KIND_PAIR;
		rec_a.name_off  = OUT_W'(line_begin_q);
		rec_a.name_size = OUT_W'(colon_off_q - line_begin_q);
		rec_a.val_off   = OUT_W'(vs);
		rec_a.val_len   = OUT_W'(text_end - vs);

		rec_b          = '0;
		rec_b.kind     = KIND_SUMMARY;
		rec_b.status   = status_ok_q ? $signed({1'b0, digits_q}) : '1;
		rec_b.pairs    = pair_total_q;
		rec_b.body_off = body_found_q ? OUT_W'(body_begin_q) : len_out;
		rec_b.last     = 1'b1;

		if (in_xfer) begin
			if (s_tuser == OP_END) begin
				if (first_done_q && !body_found_q && pair_ok) begin
					// the pair of the open line counts in the summary
					rec_b.pairs = pair_total_q + PAIR_W'(1);
					push_n      = 2'd2;
				end else begin
					rec_a  = rec_b;
					push_n = 2'd1;
				end
				// back to the reset state for the next response
				phase_d      = PH_PREFIX;
				byte_off_d   = '0;
				prefix_idx_d = '0;
				digits_d     = '0;
				status_ok_d  = 1'b0;
				digit_idx_d  = '0;
				first_done_d = 1'b0;
				line_begin_d = '0;
				colon_seen_d = 1'b0;
				colon_off_d  = '0;
				val_begin_d  = '0;
				skipping_d   = 1'b0;
				prev_cr_d    = 1'b0;
				pair_total_d = '0;
				body_begin_d = '0;
				body_found_d = 1'b0;
			end else if (byte_off_q < CNT_W'(MAX_BYTES)) begin
				byte_off_d = le_inc;

				// status line
				unique case (phase_q)
					PH_PREFIX: begin
						if (prefix_idx_q < 3'(TAG_LEN) && b == tag_byte(prefix_idx_q)) begin
							prefix_idx_d = prefix_idx_q + 3'd1;
							if (prefix_idx_q == 3'(TAG_LEN - 1))
								phase_d = PH_SCAN;
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_SCAN: begin
						if (b == CH_SPACE)
							phase_d = PH_DIGITS;
						else if (b == CH_LF)
							phase_d = PH_DONE;
					end
					PH_DIGITS: begin
						if (is_digit) begin
							digits_d    = dig_acc[DIG_W-1:0];
							digit_idx_d = digit_idx_q + 2'd1;
							if (digit_idx_q == 2'd2) begin
								status_ok_d = 1'b1;
								phase_d     = PH_DONE;
							end
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_DONE: ;
					default: ;
				endcase

				// header lines
				if (!first_done_q) begin
					if (b == CH_LF) begin
						first_done_d = 1'b1;
						line_begin_d = le_inc;
						colon_seen_d = 1'b0;
						colon_off_d  = '0;
						val_begin_d  = '0;
						skipping_d   = 1'b0;
						prev_cr_d    = 1'b0;
					end
				end else if (!body_found_q) begin
					if (b == CH_LF) begin
						if (line_empty) begin
							body_found_d = 1'b1;
							body_begin_d = le_inc;
						end else begin
							if (pair_ok) begin
								push_n       = 2'd1;
								pair_total_d = pair_total_q + PAIR_W'(1);
							end
							line_begin_d = le_inc;
							colon_seen_d = 1'b0;
							colon_off_d  = '0;
							val_begin_d  = '0;
							skipping_d   = 1'b0;
							prev_cr_d    = 1'b0;
						end
					end else begin
						if (!colon_seen_q && b == CH_COLON) begin
							colon_seen_d = 1'b1;
							colon_off_d  = le;
							skipping_d   = 1'b1;
							val_begin_d  = le_inc;
						end else if (colon_seen_q && skipping_q) begin
							if (b == CH_SPACE || b == CH_TAB)
								val_begin_d = le_inc;
							else
								skipping_d = 1'b0;
						end
						prev_cr_d = b == CH_CR;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREFIX;
			byte_off_q   <= '0;
			prefix_idx_q <= '0;
			digits_q     <= '0;
			status_ok_q  <= 1'b0;
			digit_idx_q  <= '0;
			first_done_q <= 1'b0;
			line_begin_q <= '0;
			colon_seen_q <= 1'b0;
			colon_off_q  <= '0;
			val_begin_q  <= '0;
			skipping_q   <= 1'b0;
			prev_cr_q    <= 1'b0;
			pair_total_q <= '0;
			body_begin_q <= '0;
			body_found_q <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			byte_off_q   <= byte_off_d;
			prefix_idx_q <= prefix_idx_d;
			digits_q     <= digits_d;
			status_ok_q  <= status_ok_d;
			digit_idx_q  <= digit_idx_d;
			first_done_q <= first_done_d;
			line_begin_q <= line_begin_d;
			colon_seen_q <= colon_seen_d;
			colon_off_q  <= colon_off_d;
			val_begin_q  <= val_begin_d;
			skipping_q   <= skipping_d;
			prev_cr_q    <= prev_cr_d;
			pair_total_q <= pair_total_d;
			body_begin_q <= body_begin_d;
			body_found_q <= body_found_d;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (out_xfer)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + FCNT_W'(push_n) - FCNT_W'(out_xfer);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wr_ptr_q] <= rec_a;
		if (push_n == 2'd2)
			fifo_q[wr_ptr_q + PTR_W'(1)] <= rec_b;
	end

	always_comb begin
		m_tuser = fifo_q[rd_ptr_q].kind;
		m_tlast = fifo_q[rd_ptr_q].last;
		m_tdata = {4'b0,
			fifo_q[rd_ptr_q].body_off,
			fifo_q[rd_ptr_q].pairs,
			fifo_q[rd_ptr_q].status,
			fifo_q[rd_ptr_q].val_len,
			fifo_q[rd_ptr_q].val_off,
			fifo_q[rd_ptr_q].name_size,
			fifo_q[rd_ptr_q].name_off};
	end

	// queue never overfills even with a two-record push
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FCNT_W'(FIFO_DEPTH))
		else $error("output queue overflow");

	// only the summary record closes a response
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("last flag on a pair record");

	// end marker returns the parser to its reset state
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tuser == OP_END) |=> (byte_off_q == '0 && pair_total_q == '0
			&& phase_q == PH_PREFIX))
		else $error("parser not cleared after end marker");

	assert property (@(posedge clk) disable iff (!arst_n)
		byte_off_q <= CNT_W'(MAX_BYTES))
		else $error("byte count past limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		pair_total_q <= PAIR_W'(MAX_PAIRS))
		else $error("pair count past limit");

endmodule
